// File: rtl/core/bccg_pkg.sv
// ----------------------------------------------------------------------------
// bccg_pkg
// Shared types, constants and command codes for the coulomb counter gauge.
// ----------------------------------------------------------------------------
package bccg_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CAP_BITS       = 24;
   localparam int NET_BITS       = 32;
   localparam int PCT_BITS       = 7;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 40;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_RATED_CAP  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CHG_ACTIVE = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CHG_FULL   = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_DIS_ACTIVE = 2'd3;

   localparam logic [CAP_BITS-1:0]    RATED_CAP_RST  = 24'd540000;
   localparam logic [SAMPLE_BITS-1:0] CHG_ACTIVE_RST = 12'd255;
   localparam logic [SAMPLE_BITS-1:0] CHG_FULL_RST   = 12'd32;
   localparam logic [SAMPLE_BITS-1:0] DIS_ACTIVE_RST = 12'd255;

   // battery state codes
   localparam logic [1:0] BAT_IDLE        = 2'd0;
   localparam logic [1:0] BAT_CHARGING    = 2'd1;
   localparam logic [1:0] BAT_DISCHARGING = 2'd2;

   // charge conversion: avg * SCALE / 4095 / k as a reciprocal multiply,
   // exact for 12-bit averages; the integer part starts at RECIP_SHIFT
   localparam logic [26:0] CHG_RECIP   = 27'd69922160;
   localparam logic [26:0] DIS_RECIP   = 27'd104883240;
   localparam int          RECIP_SHIFT = 31;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_BITS-1:0] PCT_MIN  = 7'd1;
   localparam logic [5:0]          ALARM_LAST   = 6'd59;
   localparam logic [5:0]          ALARM_REPORT = 6'd50;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_SAMPLE = 4'd2;
   localparam logic [3:0] OP_CAVG   = 4'd3;
   localparam logic [3:0] OP_CK     = 4'd4;
   localparam logic [3:0] OP_CNET   = 4'd5;
   localparam logic [3:0] OP_DAVG   = 4'd6;
   localparam logic [3:0] OP_DK     = 4'd7;
   localparam logic [3:0] OP_DNET   = 4'd8;
   localparam logic [3:0] OP_LEARN  = 4'd9;
   localparam logic [3:0] OP_PPREP  = 4'd10;
   localparam logic [3:0] OP_PSET   = 4'd11;
   localparam logic [3:0] OP_TEND   = 4'd12;
   localparam logic [3:0] OP_OUT    = 4'd13;

   // divider operand selects
   localparam logic [2:0] DIV_CAVG = 3'd0;
   localparam logic [2:0] DIV_DAVG = 3'd2;
   localparam logic [2:0] DIV_PCT  = 3'd4;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] div_sel;
      logic       div_start;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic pending;
      logic charge_nz;
      logic discharge_nz;
      logic div_done;
   } status_type;

endpackage

// File: rtl/core/battery_coulomb_counter_gauge_unit.sv
// ----------------------------------------------------------------------------
// battery_coulomb_counter_gauge_unit
// Coulomb counting fuel gauge: samples feed charge/discharge accumulators,
// second ticks run the alarm and produce state-of-charge reports.
// ----------------------------------------------------------------------------
//  port group | dir | transaction
//  req_*      | in  | tuser: func; tdata: charger_present[0], current_sample[12:1]
//  rsp_*      | out | tuser: report_valid; tdata: state, charger, averages, percent
//  csr_*      | in  | register write, index 0..3, no read-back
//
// Sample items run IDLE, DISP and OUT; plain ticks run IDLE, DISP, TEND, OUT.
// A reporting tick runs the shared 12-step divider up to three times
// (two averages, percent) between DISP and TEND.
// Synchronous active-high reset; the result register holds under rsp_tready
// low while the next item is accepted and worked on.
// ----------------------------------------------------------------------------
module battery_coulomb_counter_gauge_unit #(
   parameter int COUNT_BITS = bccg_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bccg_pkg::REQ_DATA_BITS-1:0] req_tdata,  // charger_present, current_sample
   input  logic                               req_tuser,  // func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bccg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // battery_state, charger_seen,
                                                         // avg_charge_reading,
                                                         // avg_discharge_reading,
                                                         // remain_percent
   output logic                               rsp_tuser,  // report_valid
   input  logic                               csr_wr_en,
   input  logic [bccg_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [bccg_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import bccg_pkg::*;

   cmd_type    cmd;
   status_type status;

   bccg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bccg_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_func    (req_tuser),
      .in_charger (req_tdata[0]),
      .in_sample  (req_tdata[SAMPLE_BITS:1]),
      .cmd        (cmd),
      .status     (status),
      .out_data   (rsp_tdata),
      .out_report (rsp_tuser)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   a_plain_zero_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[26:3] == '0)
      else $error("non-report result with averages");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:27] <= PCT_FULL)
      else $error("percent above full");

   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= BAT_DISCHARGING)
      else $error("battery state code out of range");

endmodule

// File: rtl/core/bccg_div.sv
// ----------------------------------------------------------------------------
// bccg_div
// Restoring divider, one quotient bit per cycle, quotient limited to QW bits.
// ----------------------------------------------------------------------------
module bccg_div #(
   parameter int DVW = 39,
   parameter int DSW = 24,
   parameter int QW  = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [QW-1:0]  quotient,
   output logic           overflow
);

   localparam int HW   = DVW - QW;
   localparam int CMPW = (HW > DSW) ? HW : DSW;
   localparam int CW   = $clog2(QW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DSW-1:0] rem_ff, rem_in;
   logic [DSW-1:0] div_ff, div_in;
   logic [QW-1:0]  low_ff, low_in;
   logic           ovf_ff, ovf_in;
   logic [HW-1:0]  hi;
   logic [DSW:0]   r2;
   logic           ge;

   assign hi = dividend[DVW-1:QW];
   assign r2 = {rem_ff, low_ff[QW-1]};
   assign ge = r2 >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      low_in  = low_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DSW'(hi);
         div_in  = divisor;
         low_in  = dividend[QW-1:0];
         ovf_in  = CMPW'(hi) >= CMPW'(divisor);
      end else if (busy_ff) begin
         rem_in = ge ? DSW'(r2 - {1'b0, div_ff}) : DSW'(r2);
         low_in = {low_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;
   assign overflow = ovf_ff;

endmodule

// File: rtl/core/bccg_ctrl.sv
// ----------------------------------------------------------------------------
// bccg_ctrl
// Sequencer: handshakes, report sequence and divider runs.
// ----------------------------------------------------------------------------
module bccg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output bccg_pkg::cmd_type    cmd,
   input  bccg_pkg::status_type status
);

   import bccg_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_CCHK  = 5'd2;
   localparam logic [4:0] S_CDIV1 = 5'd3;
   localparam logic [4:0] S_CAVG  = 5'd4;
   localparam logic [4:0] S_CK    = 5'd6;
   localparam logic [4:0] S_CNET  = 5'd7;
   localparam logic [4:0] S_DCHK  = 5'd8;
   localparam logic [4:0] S_DDIV1 = 5'd9;
   localparam logic [4:0] S_DAVG  = 5'd10;
   localparam logic [4:0] S_DK    = 5'd12;
   localparam logic [4:0] S_DNET  = 5'd13;
   localparam logic [4:0] S_LEARN = 5'd14;
   localparam logic [4:0] S_PPREP = 5'd15;
   localparam logic [4:0] S_PDIV  = 5'd16;
   localparam logic [4:0] S_PSET  = 5'd17;
   localparam logic [4:0] S_TEND  = 5'd18;
   localparam logic [4:0] S_OUT   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       run_ff, run_in;
   logic       rspv_ff, rspv_in;
   logic [4:0] div_next;
   logic       div_state;

   always_comb begin
      state_in  = state_ff;
      run_in    = run_ff;
      rspv_in   = rspv_ff && !rsp_tready;
      cmd       = '0;
      cmd.op    = OP_NONE;
      div_state = 1'b0;
      div_next  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!status.func) begin
               cmd.op   = OP_SAMPLE;
               state_in = S_OUT;
            end else if (status.pending) begin
               state_in = S_CCHK;
            end else begin
               state_in = S_TEND;
            end
         end
         S_CCHK:  state_in = status.charge_nz ? S_CDIV1 : S_DCHK;
         S_CDIV1: begin
            div_state   = 1'b1;
            cmd.div_sel = DIV_CAVG;
            div_next    = S_CAVG;
         end
         S_CAVG: begin
            cmd.op   = OP_CAVG;
            state_in = S_CK;
         end
         S_CK: begin
            cmd.op   = OP_CK;
            state_in = S_CNET;
         end
         S_CNET: begin
            cmd.op   = OP_CNET;
            state_in = S_DCHK;
         end
         S_DCHK:  state_in = status.discharge_nz ? S_DDIV1 : S_LEARN;
         S_DDIV1: begin
            div_state   = 1'b1;
            cmd.div_sel = DIV_DAVG;
            div_next    = S_DAVG;
         end
         S_DAVG: begin
            cmd.op   = OP_DAVG;
            state_in = S_DK;
         end
         S_DK: begin
            cmd.op   = OP_DK;
            state_in = S_DNET;
         end
         S_DNET: begin
            cmd.op   = OP_DNET;
            state_in = S_LEARN;
         end
         S_LEARN: begin
            cmd.op   = OP_LEARN;
            state_in = S_PPREP;
         end
         S_PPREP: begin
            cmd.op   = OP_PPREP;
            state_in = S_PDIV;
         end
         S_PDIV: begin
            div_state   = 1'b1;
            cmd.div_sel = DIV_PCT;
            div_next    = S_PSET;
         end
         S_PSET: begin
            cmd.op   = OP_PSET;
            state_in = S_TEND;
         end
         S_TEND: begin
            cmd.op   = OP_TEND;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rspv_ff || rsp_tready) begin
               cmd.op   = OP_OUT;
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (div_state) begin
         if (!run_ff) begin
            cmd.div_start = 1'b1;
            run_in        = 1'b1;
         end else if (status.div_done) begin
            run_in   = 1'b0;
            state_in = div_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rspv_ff;

endmodule

// File: rtl/core/bccg_dpath.sv
// ----------------------------------------------------------------------------
// bccg_dpath
// Gauge state, accumulators, charge integration and the shared divider.
// ----------------------------------------------------------------------------
module bccg_dpath #(
   parameter int COUNT_BITS = bccg_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bccg_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [bccg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 in_func,
   input  logic                                 in_charger,
   input  logic [bccg_pkg::SAMPLE_BITS-1:0]     in_sample,
   input  bccg_pkg::cmd_type                     cmd,
   output bccg_pkg::status_type                  status,
   output logic [bccg_pkg::RSP_DATA_BITS-1:0]   out_data,
   output logic                                 out_report
);

   import bccg_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int DVW      = (SUM_BITS > 39) ? SUM_BITS : 39;
   localparam int DSW      = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
   localparam int QW       = SAMPLE_BITS;
   localparam int PAD_BITS = RSP_DATA_BITS - 2 - 1 - 2 * SAMPLE_BITS - PCT_BITS;

   logic [CAP_BITS-1:0]    rated_ff;
   logic [SAMPLE_BITS-1:0] cact_ff, cfull_ff, dact_ff;

   logic                   func_ff, chg_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic [1:0]             status_ff, status_in;
   logic                   charger_ff;
   logic                   pending_ff;
   logic                   empty_mark_ff, empty_mark_in;
   logic                   full_mark_ff, full_mark_in;
   logic [SUM_BITS-1:0]    csum_ff, dsum_ff;
   logic [COUNT_BITS-1:0]  ccnt_ff, dcnt_ff;
   logic [NET_BITS-1:0]    net_ff;
   logic [CAP_BITS-1:0]    learned_ff;
   logic [5:0]             alarm_ff, alarm_in;
   logic [7:0]             elapsed_ff;
   logic [PCT_BITS-1:0]    pct_ff, pct_in;
   logic [SAMPLE_BITS-1:0] avgc_ff, avgd_ff;
   logic                   report_ff;
   logic                   lowclamp_ff, pos_ff;

   logic [DVW-1:0]         prod_ff;
   logic [15:0]            kt_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff;
   logic                   out_report_ff;

   logic                   div_done, div_ovf;
   logic [QW-1:0]          div_q;
   logic [DVW-1:0]         div_dividend;
   logic [DSW-1:0]         div_divisor;
   logic [CAP_BITS-1:0]    cap_eff;

   logic [SAMPLE_BITS+26:0] scale_prod;
   logic [26:0]             scale_sel;
   logic [33:0]             net_ext, net_res;
   logic [NET_BITS-1:0]     net_sat;
   logic [32:0]             net33, neg33, mag33, rated33;
   logic                    learn_hit;
   logic                    net_pos;
   logic [33:0]             soc_sum;
   logic                    soc_le0;
   logic [DVW-1:0]          pct_dividend;
   logic                    alarm_hit;

   assign cap_eff = (learned_ff == '0) ? CAP_BITS'(1) : learned_ff;

   always_comb begin
      div_dividend = '0;
      div_divisor  = DSW'(1);
      case (cmd.div_sel)
         DIV_CAVG: begin
            div_dividend = DVW'(csum_ff);
            div_divisor  = DSW'(ccnt_ff);
         end
         DIV_DAVG: begin
            div_dividend = DVW'(dsum_ff);
            div_divisor  = DSW'(dcnt_ff);
         end
         DIV_PCT: begin
            div_dividend = prod_ff;
            div_divisor  = DSW'(cap_eff);
         end
         default: ;
      endcase
   end

   bccg_div #(
      .DVW (DVW),
      .DSW (DSW),
      .QW  (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q),
      .overflow (div_ovf)
   );

   // sample classification
   always_comb begin
      status_in     = status_ff;
      full_mark_in  = full_mark_ff;
      empty_mark_in = empty_mark_ff;
      if (chg_ff) begin
         if (smp_ff > cact_ff) begin
            status_in    = BAT_CHARGING;
            full_mark_in = 1'b0;
         end else if (smp_ff < cfull_ff) begin
            status_in    = BAT_IDLE;
            full_mark_in = 1'b1;
         end
      end else if (smp_ff > dact_ff) begin
         status_in     = BAT_DISCHARGING;
         empty_mark_in = 1'b0;
      end else begin
         status_in     = BAT_IDLE;
         empty_mark_in = 1'b1;
      end
   end

   assign scale_sel  = (cmd.op == OP_CAVG) ? CHG_RECIP : DIS_RECIP;
   assign scale_prod = (SAMPLE_BITS + 27)'(div_q) * (SAMPLE_BITS + 27)'(scale_sel);

   // net charge integration with saturation
   assign net_ext = {{2{net_ff[NET_BITS-1]}}, net_ff};
   assign net_res = (cmd.op == OP_CNET) ? net_ext + {18'd0, kt_ff}
                                        : net_ext - {18'd0, kt_ff};
   always_comb begin
      if (net_res[33:31] == 3'b000 || net_res[33:31] == 3'b111) begin
         net_sat = net_res[NET_BITS-1:0];
      end else if (net_res[33]) begin
         net_sat = 32'h8000_0000;
      end else begin
         net_sat = 32'h7FFF_FFFF;
      end
   end

   // capacity learning
   assign net33     = {net_ff[NET_BITS-1], net_ff};
   assign neg33     = 33'd0 - net33;
   assign rated33   = {9'd0, rated_ff};
   assign mag33     = net_ff[NET_BITS-1] ? neg33 : net33;
   assign learn_hit = (!net_ff[NET_BITS-1] && net33 > rated33 && empty_mark_ff) ||
                      (net_ff[NET_BITS-1] && neg33 > rated33 && full_mark_ff);

   // percent preparation
   assign net_pos = !net_ff[NET_BITS-1] && (net_ff != '0);
   assign soc_sum = {10'd0, cap_eff} + net_ext;
   assign soc_le0 = soc_sum[33] || (soc_sum == '0);
   assign pct_dividend = net_pos ? DVW'(38'(net_ff[30:0]) * 38'd100)
                                 : DVW'(31'(soc_sum[23:0]) * 31'd100);

   always_comb begin
      if (lowclamp_ff) begin
         pct_in = PCT_MIN;
      end else if (div_ovf || div_q > QW'(PCT_FULL)) begin
         pct_in = PCT_FULL;
      end else if (!pos_ff && div_q == '0) begin
         pct_in = PCT_MIN;
      end else begin
         pct_in = div_q[PCT_BITS-1:0];
      end
   end

   assign alarm_in  = (alarm_ff == ALARM_LAST) ? 6'd0 : alarm_ff + 6'd1;
   assign alarm_hit = (alarm_in == 6'd0) || (alarm_in == ALARM_REPORT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rated_ff      <= RATED_CAP_RST;
         cact_ff       <= CHG_ACTIVE_RST;
         cfull_ff      <= CHG_FULL_RST;
         dact_ff       <= DIS_ACTIVE_RST;
         func_ff       <= 1'b0;
         chg_ff        <= 1'b0;
         smp_ff        <= '0;
         status_ff     <= BAT_IDLE;
         charger_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         empty_mark_ff <= 1'b0;
         full_mark_ff  <= 1'b0;
         csum_ff       <= '0;
         ccnt_ff       <= '0;
         dsum_ff       <= '0;
         dcnt_ff       <= '0;
         net_ff        <= '0;
         learned_ff    <= RATED_CAP_RST;
         alarm_ff      <= '0;
         elapsed_ff    <= 8'd1;
         pct_ff        <= '0;
         avgc_ff       <= '0;
         avgd_ff       <= '0;
         report_ff     <= 1'b0;
         lowclamp_ff   <= 1'b0;
         pos_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               REG_RATED_CAP:  rated_ff <= csr_wdata[CAP_BITS-1:0];
               REG_CHG_ACTIVE: cact_ff  <= csr_wdata[SAMPLE_BITS-1:0];
               REG_CHG_FULL:   cfull_ff <= csr_wdata[SAMPLE_BITS-1:0];
               REG_DIS_ACTIVE: dact_ff  <= csr_wdata[SAMPLE_BITS-1:0];
               default: ;
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               func_ff   <= in_func;
               chg_ff    <= in_charger;
               smp_ff    <= in_sample;
               avgc_ff   <= '0;
               avgd_ff   <= '0;
               report_ff <= 1'b0;
            end
            OP_SAMPLE: begin
               charger_ff    <= chg_ff;
               status_ff     <= status_in;
               full_mark_ff  <= full_mark_in;
               empty_mark_ff <= empty_mark_in;
               if (status_in != status_ff) begin
                  pending_ff <= 1'b1;
               end
               if (chg_ff) begin
                  if (ccnt_ff != '1) begin
                     csum_ff <= csum_ff + SUM_BITS'(smp_ff);
                     ccnt_ff <= ccnt_ff + 1'b1;
                  end
               end else if (dcnt_ff != '1) begin
                  dsum_ff <= dsum_ff + SUM_BITS'(smp_ff);
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            OP_CAVG: begin
               avgc_ff <= div_q;
               csum_ff <= '0;
               ccnt_ff <= '0;
            end
            OP_DAVG: begin
               avgd_ff <= div_q;
               dsum_ff <= '0;
               dcnt_ff <= '0;
            end
            OP_CNET, OP_DNET: net_ff <= net_sat;
            OP_LEARN: begin
               if (learn_hit) begin
                  learned_ff <= (mag33[32:24] != '0) ? '1 : mag33[CAP_BITS-1:0];
               end
            end
            OP_PPREP: begin
               pos_ff      <= net_pos;
               lowclamp_ff <= !net_pos && soc_le0;
            end
            OP_PSET: pct_ff <= pct_in;
            OP_TEND: begin
               report_ff  <= pending_ff;
               alarm_ff   <= alarm_in;
               pending_ff <= alarm_hit;
               elapsed_ff <= (pending_ff ? 8'd1 : elapsed_ff) + 8'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAVG, OP_DAVG: prod_ff <= DVW'(scale_prod);
         OP_PPREP:         prod_ff <= pct_dividend;
         default: ;
      endcase
      if (cmd.op == OP_CK || cmd.op == OP_DK) begin
         kt_ff <= 16'(prod_ff[RECIP_SHIFT+7:RECIP_SHIFT]) * 16'(elapsed_ff);
      end
      if (cmd.op == OP_OUT) begin
         out_data_ff   <= {{PAD_BITS{1'b0}}, pct_ff, avgd_ff, avgc_ff, charger_ff, status_ff};
         out_report_ff <= report_ff;
      end
   end

   assign status.func         = func_ff;
   assign status.pending      = pending_ff;
   assign status.charge_nz    = ccnt_ff != '0;
   assign status.discharge_nz = dcnt_ff != '0;
   assign status.div_done     = div_done;

   assign out_data   = out_data_ff;
   assign out_report = out_report_ff;

endmodule
